// ----- src/ptl_pkg.sv -----
// Shared types, codes and default constants of the paged translation core.
package ptl_pkg;

    // Defaults of the top-level parameters.
    localparam int PAGE_COUNT_DEF  = 16;
    localparam int OFFSET_BITS_DEF = 10;
    localparam int FRAME_BITS_DEF  = 8;

    // Fixed field widths.
    localparam int CNT_W     = 5;   // frame_count register
    localparam int CFG_IDX_W = 2;   // configuration register index
    localparam int TOTAL_W   = 32;  // running totals

    // Reset values of the frame pool registers.
    localparam int FRAME_BASE_RST  = 32;
    localparam int FRAME_COUNT_RST = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VALID_MASK    = 2'd0,
        CFG_WRITABLE_MASK = 2'd1,
        CFG_FRAME_BASE    = 2'd2,
        CFG_FRAME_COUNT   = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_READONLY = 2'd2
    } t_status;

    // Per-result flags handed from the table walker to the output stage.
    typedef struct packed {
        t_status status;
        logic    fault;
        logic    wb;
        logic    is_write;
    } t_flags;

endpackage

// ----- src/ptl_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ptl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ptl_ctrl.sv -----
// Page table walker: lookup, LRU victim scan, recency update and entry write-back.
module ptl_ctrl import ptl_pkg::*; #(
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF,
    localparam int PAGE_BITS  = $clog2(PAGE_COUNT),
    localparam int VA_W       = OFFSET_BITS + PAGE_BITS,
    localparam int PHYS_W     = FRAME_BITS + OFFSET_BITS,
    localparam int ENT_W      = 1 + FRAME_BITS + PAGE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic [PAGE_COUNT-1:0]  i_valid_mask,
    input  logic [PAGE_COUNT-1:0]  i_writable_mask,
    input  logic [FRAME_BITS-1:0]  i_frame_base,
    input  logic [CNT_W-1:0]       i_frame_count,
    // reference in
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_opcode,
    input  logic [VA_W-1:0]        i_vaddr,
    // result out
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output t_flags                 o_flags,
    output logic [PAGE_BITS-1:0]   o_page,
    output logic [OFFSET_BITS-1:0] o_offset,
    output logic [PHYS_W-1:0]      o_phys,
    // page table RAM
    output logic                   o_ram_we,
    output logic [PAGE_BITS-1:0]   o_ram_waddr,
    output logic [ENT_W-1:0]       o_ram_wdata,
    output logic [PAGE_BITS-1:0]   o_ram_raddr,
    input  logic [ENT_W-1:0]       i_ram_rdata
);

    localparam int HAND_W = $clog2(PAGE_COUNT + 1);
    localparam int CMP_W  = (HAND_W > CNT_W) ? HAND_W : CNT_W;
    localparam int SUM_W  = (HAND_W > FRAME_BITS) ? HAND_W : FRAME_BITS;
    localparam logic [PAGE_BITS-1:0] LAST = PAGE_BITS'(PAGE_COUNT - 1);

    typedef struct packed {
        logic                  modified;
        logic [FRAME_BITS-1:0] frame;
        logic [PAGE_BITS-1:0]  rank;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_SCAN, S_EVICT, S_TOUCH, S_FINAL, S_DONE
    } t_state;

    t_state                  r_state;
    t_flags                  r_flags;
    logic                    r_is_write;
    logic [PAGE_BITS-1:0]    r_page;
    logic [OFFSET_BITS-1:0]  r_offset;
    logic [PHYS_W-1:0]       r_phys;
    logic                    r_was_present;
    logic                    r_old_mod;
    logic [PAGE_BITS-1:0]    r_old_rank;
    logic [FRAME_BITS-1:0]   r_frame;
    logic [PAGE_BITS-1:0]    r_idx;
    logic                    r_found;
    logic [PAGE_BITS-1:0]    r_best_idx;
    logic [PAGE_BITS-1:0]    r_best_rank;
    logic [FRAME_BITS-1:0]   r_best_frame;
    logic                    r_best_mod;
    logic [PAGE_COUNT-1:0]   r_present;
    logic [HAND_W-1:0]       r_handed;

    t_entry                  rd_ent;
    t_entry                  wr_ent;
    logic [PAGE_BITS-1:0]    vpn;
    logic [PAGE_BITS-1:0]    in_page;
    t_status                 in_status;
    logic [CNT_W-1:0]        pool;
    logic                    pool_avail;
    logic [SUM_W-1:0]        frame_sum;
    logic [PAGE_BITS-1:0]    idx_next;

    assign rd_ent = t_entry'(i_ram_rdata);

    // Page select: the address page field reduced modulo the table size.
    assign vpn     = i_vaddr[VA_W-1:OFFSET_BITS];
    assign in_page = ({1'b0, vpn} >= (PAGE_BITS+1)'(PAGE_COUNT))
                   ? vpn - PAGE_BITS'(PAGE_COUNT) : vpn;

    always_comb begin
        if (!i_valid_mask[in_page]) begin
            in_status = ST_INVALID;
        end else if (i_opcode && !i_writable_mask[in_page]) begin
            in_status = ST_READONLY;
        end else begin
            in_status = ST_OK;
        end
    end

    // Free-frame pool: a zero count behaves as one frame.
    assign pool       = (i_frame_count == '0) ? CNT_W'(1) : i_frame_count;
    assign pool_avail = (CMP_W'(r_handed) < CMP_W'(pool))
                     && (r_handed < HAND_W'(PAGE_COUNT));
    assign frame_sum  = SUM_W'(i_frame_base) + SUM_W'(r_handed);

    assign idx_next = (r_idx == LAST) ? '0 : r_idx + 1'b1;

    // RAM address and write control.
    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx;
        wr_ent      = rd_ent;
        wr_ent.rank = rd_ent.rank + 1'b1;
        o_ram_raddr = '0;
        case (r_state)
            S_IDLE: begin
                o_ram_raddr = in_page;
            end
            S_SCAN: begin
                o_ram_raddr = idx_next;
            end
            S_TOUCH: begin
                o_ram_raddr = idx_next;
                // Age resident pages more recent than the touched one, or all of them if it was absent.
                o_ram_we = r_present[r_idx] && (r_idx != r_page)
                        && (!r_was_present || rd_ent.rank < r_old_rank);
            end
            S_FINAL: begin
                o_ram_we        = 1'b1;
                o_ram_waddr     = r_page;
                wr_ent.modified = (r_was_present & r_old_mod) | r_is_write;
                wr_ent.frame    = r_frame;
                wr_ent.rank     = '0;
            end
            default: begin
                o_ram_raddr = '0;
            end
        endcase
    end

    assign o_ram_wdata = ENT_W'(wr_ent);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= '0;
            r_handed  <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_is_write <= i_opcode;
                        r_page     <= in_page;
                        r_offset   <= i_vaddr[OFFSET_BITS-1:0];
                        r_phys     <= '0;
                        r_flags    <= '{status: in_status, fault: 1'b0, wb: 1'b0,
                                        is_write: i_opcode};
                        r_state    <= (in_status == ST_OK) ? S_LOOK : S_DONE;
                    end
                end
                S_LOOK: begin
                    r_was_present <= r_present[r_page];
                    r_old_mod     <= rd_ent.modified;
                    r_old_rank    <= rd_ent.rank;
                    r_idx         <= '0;
                    r_found       <= 1'b0;
                    if (r_present[r_page]) begin
                        r_frame <= rd_ent.frame;
                        r_state <= S_TOUCH;
                    end else begin
                        r_flags.fault <= 1'b1;
                        if (pool_avail) begin
                            r_frame  <= frame_sum[FRAME_BITS-1:0];
                            r_handed <= r_handed + 1'b1;
                            r_state  <= S_TOUCH;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_present[r_idx] && (!r_found || rd_ent.rank > r_best_rank)) begin
                        r_found      <= 1'b1;
                        r_best_idx   <= r_idx;
                        r_best_rank  <= rd_ent.rank;
                        r_best_frame <= rd_ent.frame;
                        r_best_mod   <= rd_ent.modified;
                    end
                    r_idx <= idx_next;
                    if (r_idx == LAST) begin
                        r_state <= S_EVICT;
                    end
                end
                S_EVICT: begin
                    if (r_found) begin
                        r_flags.wb             <= r_best_mod;
                        r_frame                <= r_best_frame;
                        r_present[r_best_idx]  <= 1'b0;
                    end else begin
                        r_frame <= i_frame_base;
                    end
                    r_idx   <= '0;
                    r_state <= S_TOUCH;
                end
                S_TOUCH: begin
                    r_idx <= idx_next;
                    if (r_idx == LAST) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    r_present[r_page] <= 1'b1;
                    r_phys            <= {r_frame, r_offset};
                    r_state           <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_flags     = r_flags;
    assign o_page      = r_page;
    assign o_offset    = r_offset;
    assign o_phys      = r_phys;

    // Between references every handed-out frame backs exactly one resident page.
    a_resident_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_present) == int'(r_handed)))
        else $error("resident page count differs from frames handed out");

    a_hand_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_handed <= HAND_W'(PAGE_COUNT))
        else $error("more frames handed out than pages");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !o_ram_we)
        else $error("page table written outside a walk");

    a_scan_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) ##1 (r_state == S_SCAN) |-> ($past(r_handed) != '0))
        else $error("victim scan started with an empty table");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted reference did not start processing");

endmodule

// ----- src/ptl_out.sv -----
// Output stage: saturating running totals and the result word register.
module ptl_out import ptl_pkg::*; #(
    parameter int PAGE_BITS   = 4,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int PHYS_W      = 18,
    parameter int DATA_W      = 168
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_ready,
    input  t_flags                 i_flags,
    input  logic [PAGE_BITS-1:0]   i_page,
    input  logic [OFFSET_BITS-1:0] i_offset,
    input  logic [PHYS_W-1:0]      i_phys,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [DATA_W-1:0]      o_tdata
);

    localparam int USED_W = 2 + PAGE_BITS + OFFSET_BITS + 2 + PHYS_W + 4 * TOTAL_W;
    localparam logic [TOTAL_W-1:0] SAT = '1;

    logic               r_tvalid;
    logic [DATA_W-1:0]  r_tdata;
    logic [TOTAL_W-1:0] r_read_total, r_write_total, r_fault_total, r_wb_total;
    logic [TOTAL_W-1:0] n_read_total, n_write_total, n_fault_total, n_wb_total;
    logic               ok;
    logic               take;

    assign o_ready = !r_tvalid || i_tready;
    assign take    = i_push && o_ready;
    assign ok      = (i_flags.status == ST_OK);

    always_comb begin
        n_read_total  = r_read_total;
        n_write_total = r_write_total;
        n_fault_total = r_fault_total;
        n_wb_total    = r_wb_total;
        if (ok && !i_flags.is_write && r_read_total != SAT) begin
            n_read_total = r_read_total + 1'b1;
        end
        if (ok && i_flags.is_write && r_write_total != SAT) begin
            n_write_total = r_write_total + 1'b1;
        end
        if (i_flags.fault && r_fault_total != SAT) begin
            n_fault_total = r_fault_total + 1'b1;
        end
        if (i_flags.wb && r_wb_total != SAT) begin
            n_wb_total = r_wb_total + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid      <= 1'b0;
            r_read_total  <= '0;
            r_write_total <= '0;
            r_fault_total <= '0;
            r_wb_total    <= '0;
        end else begin
            if (take) begin
                r_tvalid      <= 1'b1;
                r_read_total  <= n_read_total;
                r_write_total <= n_write_total;
                r_fault_total <= n_fault_total;
                r_wb_total    <= n_wb_total;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tdata <= DATA_W'({n_wb_total, n_fault_total, n_write_total, n_read_total,
                                i_phys, i_flags.wb, i_flags.fault, i_offset, i_page,
                                i_flags.status});
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;

    a_width_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (USED_W <= DATA_W))
        else $error("result word narrower than its fields");

endmodule

// ----- src/paged_translation_lru_core.sv -----
// Paged address translation core with LRU replacement: top level.
//
// Each reference word carries an opcode (read or write) and a virtual address whose
// upper bits select one of PAGE_COUNT pages. Pages outside valid_mask, and writes
// to pages outside writable_mask, are rejected without any state change. A miss on a
// valid page faults: it takes the next frame of the pool frame_base.. of frame_count
// frames, or, once the pool is used, evicts the least recently used resident page and
// reuses its frame, flagging a write-back if that page was modified. Each result word
// carries status, page, offset, fault and write-back flags, the physical address and
// four saturating running totals. The page table (modified bit, frame, recency rank)
// lives in one RAM with a registered read; resident bits are flip-flops cleared by
// reset, so the RAM needs no clearing pass. One reference is processed at a time and
// the rate is set by sweeps over the page table RAM, one entry a cycle: a rejected
// reference goes straight to its result with no sweep, a hit or a fault served from
// the free pool takes one recency-update sweep, and a fault that evicts takes a
// victim scan sweep then the recency sweep. A finished result sits in the output
// register, so the next reference is accepted while the previous result waits to be
// taken. Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_wdata; the
// user must write it only while idle, as the block itself does not enforce this.
module paged_translation_lru_core import ptl_pkg::*; #(
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF,
    localparam int PAGE_BITS  = $clog2(PAGE_COUNT),
    localparam int VA_W       = OFFSET_BITS + PAGE_BITS,
    localparam int PHYS_W     = FRAME_BITS + OFFSET_BITS,
    localparam int IN_W       = ((VA_W + 7) / 8) * 8,
    localparam int OUT_USED   = 2 + PAGE_BITS + OFFSET_BITS + 2 + PHYS_W + 4 * TOTAL_W,
    localparam int OUT_W      = ((OUT_USED + 7) / 8) * 8,
    localparam int CFG_W0     = (PAGE_COUNT > FRAME_BITS) ? PAGE_COUNT : FRAME_BITS,
    localparam int CFG_W      = (CFG_W0 > CNT_W) ? CFG_W0 : CNT_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // reference stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,  // virtual_address, zero pad
    input  logic [0:0]           s_axis_tuser,  // opcode
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // status, page_number, page_offset, page_fault, write_back, physical_address,
    // read_total, write_total, fault_total, writeback_total, zero pad
    output logic [OUT_W-1:0]     m_axis_tdata
);

    localparam int ENT_W = 1 + FRAME_BITS + PAGE_BITS;

    // Configuration registers.
    logic [PAGE_COUNT-1:0] r_valid_mask;
    logic [PAGE_COUNT-1:0] r_writable_mask;
    logic [FRAME_BITS-1:0] r_frame_base;
    logic [CNT_W-1:0]      r_frame_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_mask    <= '0;
            r_writable_mask <= '0;
            r_frame_base    <= FRAME_BITS'(FRAME_BASE_RST);
            r_frame_count   <= CNT_W'(FRAME_COUNT_RST);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_VALID_MASK:    r_valid_mask    <= i_cfg_wdata[PAGE_COUNT-1:0];
                CFG_WRITABLE_MASK: r_writable_mask <= i_cfg_wdata[PAGE_COUNT-1:0];
                CFG_FRAME_BASE:    r_frame_base    <= i_cfg_wdata[FRAME_BITS-1:0];
                CFG_FRAME_COUNT:   r_frame_count   <= i_cfg_wdata[CNT_W-1:0];
                default: begin
                    r_frame_count <= r_frame_count;
                end
            endcase
        end
    end

    // Walker to output stage.
    logic                   res_valid;
    logic                   res_ready;
    t_flags                 res_flags;
    logic [PAGE_BITS-1:0]   res_page;
    logic [OFFSET_BITS-1:0] res_offset;
    logic [PHYS_W-1:0]      res_phys;

    // Page table RAM.
    logic                   ram_we;
    logic [PAGE_BITS-1:0]   ram_waddr;
    logic [ENT_W-1:0]       ram_wdata;
    logic [PAGE_BITS-1:0]   ram_raddr;
    logic [ENT_W-1:0]       ram_rdata;

    ptl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (PAGE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ptl_ctrl #(
        .PAGE_COUNT  (PAGE_COUNT),
        .OFFSET_BITS (OFFSET_BITS),
        .FRAME_BITS  (FRAME_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid_mask    (r_valid_mask),
        .i_writable_mask (r_writable_mask),
        .i_frame_base    (r_frame_base),
        .i_frame_count   (r_frame_count),
        .i_in_valid      (s_axis_tvalid),
        .o_in_ready      (s_axis_tready),
        .i_opcode        (s_axis_tuser[0]),
        .i_vaddr         (s_axis_tdata[VA_W-1:0]),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_flags         (res_flags),
        .o_page          (res_page),
        .o_offset        (res_offset),
        .o_phys          (res_phys),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_raddr     (ram_raddr),
        .i_ram_rdata     (ram_rdata)
    );

    ptl_out #(
        .PAGE_BITS   (PAGE_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .PHYS_W      (PHYS_W),
        .DATA_W      (OUT_W)
    ) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_valid),
        .o_ready  (res_ready),
        .i_flags  (res_flags),
        .i_page   (res_page),
        .i_offset (res_offset),
        .i_phys   (res_phys),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule

// ----- test/paged_translation_lru_core_tb.sv -----
// Self-checking stream testbench for the paged translation core with LRU replacement.
`timescale 1ns / 100ps

module paged_translation_lru_core_tb;
    import ptl_pkg::*;

    // Reference word opcodes, carried on s_axis_tuser.
    typedef enum bit {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    // One result word as packed on m_axis_tdata, lowest field last.
    typedef struct packed {
        logic [31:0] wb_total;
        logic [31:0] fault_total;
        logic [31:0] write_total;
        logic [31:0] read_total;
        logic [17:0] phys;
        logic        wb;
        logic        fault;
        logic [9:0]  offset;
        logic [3:0]  page;
        t_status     status;
    } t_xlat;

    localparam int XLAT_W = $bits(t_xlat);

    typedef enum bit {
        ROW_CFG,
        ROW_REF
    } t_row_kind;

    // One line of the directed table. Rows marked typed carry their flags and
    // physical address by hand; the totals always come from the predictor.
    typedef struct {
        t_row_kind   kind;
        t_op         op;
        logic [13:0] va;
        t_cfg_reg    reg_idx;
        logic [15:0] value;
        bit          typed;
        t_status     st;
        bit          fault;
        bit          wb;
        logic [17:0] phys;
    } t_stim_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    t_cfg_reg     i_cfg_addr = CFG_VALID_MASK;
    logic [15:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata = '0;   // virtual_address, zero pad
    logic [0:0]   s_axis_tuser = '0;   // opcode
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // status, page_number, page_offset, page_fault, write_back, physical_address,
    // read_total, write_total, fault_total, writeback_total, zero pad
    logic [167:0] m_axis_tdata;

    paged_translation_lru_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("FAIL paged_translation_lru_core");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: a private copy of the page table, registers and totals.
    // ------------------------------------------------------------------
    logic [15:0]  valid_q = '0;
    logic [15:0]  writable_q = '0;
    logic [7:0]   frame_base_q = 8'(FRAME_BASE_RST);
    logic [4:0]   frame_cnt_q = 5'(FRAME_COUNT_RST);

    bit           resident [16];
    bit           dirty [16];
    logic [7:0]   frame_of [16];
    int unsigned  rank_of [16];   // 0 = most recently used among resident pages
    int unsigned  handed_out = 0;
    logic [31:0]  reads = '0;
    logic [31:0]  writes = '0;
    logic [31:0]  faults = '0;
    logic [31:0]  writebacks = '0;

    t_xlat        expected_xlats [$];
    int           mismatches = 0;
    bit           stall_out_req = 0;   // ask the result side for one long hold-off

    initial begin
        for (int p = 0; p < 16; p++) begin
            resident[p] = 0;
            dirty[p]    = 0;
            frame_of[p] = '0;
            rank_of[p]  = 0;
        end
    end

    function automatic logic [31:0] sat_up(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    // Make page p the most recent; resident pages newer than it (all, if p was absent) age by one.
    function automatic void bump_recency(int p);
        bit          was_resident;
        int unsigned old_rank;
        was_resident = resident[p];
        old_rank     = rank_of[p];
        for (int q = 0; q < 16; q++) begin
            if (q != p && resident[q] && (!was_resident || rank_of[q] < old_rank))
                rank_of[q]++;
        end
        rank_of[p] = 0;
    endfunction

    function automatic t_xlat predict_translation(t_op op, logic [13:0] va);
        t_xlat       r;
        logic [3:0]  pg;
        logic [7:0]  frm;
        int unsigned pool;
        int          victim;
        bit          found;
        r      = '0;
        pg     = va[13:10];
        r.page = pg;
        r.offset = va[9:0];
        pool   = (frame_cnt_q == 0) ? 1 : frame_cnt_q;
        if (!valid_q[pg]) begin
            r.status = ST_INVALID;
        end else if (op == OP_WRITE && !writable_q[pg]) begin
            r.status = ST_READONLY;
        end else begin
            r.status = ST_OK;
            if (!resident[pg]) begin
                r.fault = 1'b1;
                faults  = sat_up(faults);
                if (handed_out < pool && handed_out < 16) begin
                    // take the next free frame, wrapping in the frame field
                    frm = frame_base_q + 8'(handed_out);
                    handed_out++;
                end else begin
                    // evict the least recent resident page
                    found  = 0;
                    victim = 0;
                    for (int q = 0; q < 16; q++) begin
                        if (resident[q] && (!found || rank_of[q] > rank_of[victim])) begin
                            victim = q;
                            found  = 1;
                        end
                    end
                    if (found) begin
                        if (dirty[victim]) begin
                            r.wb       = 1'b1;
                            writebacks = sat_up(writebacks);
                        end
                        frm              = frame_of[victim];
                        resident[victim] = 0;
                        dirty[victim]    = 0;
                        rank_of[victim]  = 0;
                    end else begin
                        frm = frame_base_q;
                    end
                end
                bump_recency(pg);
                resident[pg] = 1;
                dirty[pg]    = 0;
                frame_of[pg] = frm;
            end else begin
                bump_recency(pg);
            end
            if (op == OP_WRITE) begin
                writes    = sat_up(writes);
                dirty[pg] = 1;
            end else begin
                reads = sat_up(reads);
            end
            r.phys = {frame_of[pg], va[9:0]};
        end
        r.read_total  = reads;
        r.write_total = writes;
        r.fault_total = faults;
        r.wb_total    = writebacks;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders.
    // ------------------------------------------------------------------
    function automatic t_stim_row cfg_row(t_cfg_reg idx, logic [15:0] v);
        t_stim_row r;
        r.kind    = ROW_CFG;
        r.op      = OP_READ;
        r.va      = '0;
        r.reg_idx = idx;
        r.value   = v;
        r.typed   = 0;
        r.st      = ST_OK;
        r.fault   = 0;
        r.wb      = 0;
        r.phys    = '0;
        return r;
    endfunction

    function automatic t_stim_row ref_row(t_op op, logic [13:0] va);
        t_stim_row r;
        r.kind    = ROW_REF;
        r.op      = op;
        r.va      = va;
        r.reg_idx = CFG_VALID_MASK;
        r.value   = '0;
        r.typed   = 0;
        r.st      = ST_OK;
        r.fault   = 0;
        r.wb      = 0;
        r.phys    = '0;
        return r;
    endfunction

    function automatic t_stim_row chk_row(t_op op, logic [13:0] va, t_status st, bit fault,
                                          bit wb, logic [17:0] phys);
        t_stim_row r;
        r       = ref_row(op, va);
        r.typed = 1;
        r.st    = st;
        r.fault = fault;
        r.wb    = wb;
        r.phys  = phys;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reference side.
    // ------------------------------------------------------------------

    // Drop valid and hold until every expected result word has been taken.
    task automatic drain_results();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (expected_xlats.size() != 0) @(posedge i_clk);
    endtask

    // Registers change only with nothing in flight; the predictor follows.
    task automatic cfg_write(t_cfg_reg idx, logic [15:0] v);
        drain_results();
        @(negedge i_clk) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx;
            i_cfg_wdata <= v;
        end
        case (idx)
            CFG_VALID_MASK:    valid_q      = v;
            CFG_WRITABLE_MASK: writable_q   = v;
            CFG_FRAME_BASE:    frame_base_q = v[7:0];
            CFG_FRAME_COUNT:   frame_cnt_q  = v[4:0];
            default: ;
        endcase
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    // Offer one reference word, hold it until taken, then record its expectation.
    task automatic send_ref(t_stim_row row);
        t_xlat exp_x;
        @(negedge i_clk) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {2'b00, row.va};
            s_axis_tuser  <= row.op;
        end
        do @(posedge i_clk); while (!s_axis_tready);
        exp_x = predict_translation(row.op, row.va);
        if (row.typed) begin
            exp_x.status = row.st;
            exp_x.fault  = row.fault;
            exp_x.wb     = row.wb;
            exp_x.phys   = row.phys;
        end
        expected_xlats.push_back(exp_x);
    endtask

    // Mostly valid pages, so that faults and evictions dominate over rejects.
    function automatic logic [3:0] pick_page();
        logic [3:0] p;
        p = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 85) begin
            for (int t = 0; t < 32 && !valid_q[p]; t++)
                p = 4'($urandom_range(0, 15));
        end
        return p;
    endfunction

    t_stim_row directed [$];

    initial begin
        t_stim_row   row;
        logic [3:0]  pg;
        t_op         op;
        int          burst_left;
        int          gap;
        logic [4:0]  cnt_sel;

        // reset held low from the start, released on a falling edge
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // After reset nothing is valid; validity wins even over a write.
        directed.push_back(chk_row(OP_READ,  14'h0000, ST_INVALID, 0, 0, 18'h0));
        directed.push_back(chk_row(OP_WRITE, 14'h3FFF, ST_INVALID, 0, 0, 18'h0));
        // Top frame base and a zero frame count: a pool of one frame.
        directed.push_back(cfg_row(CFG_VALID_MASK,    16'hFFFF));
        directed.push_back(cfg_row(CFG_WRITABLE_MASK, 16'h00FF));
        directed.push_back(cfg_row(CFG_FRAME_BASE,    16'h00FF));
        directed.push_back(cfg_row(CFG_FRAME_COUNT,   16'h0000));
        directed.push_back(chk_row(OP_READ,  14'h03FF, ST_OK, 1, 0, 18'h3FFFF));
        directed.push_back(chk_row(OP_WRITE, 14'h0000, ST_OK, 0, 0, 18'h3FC00));
        directed.push_back(chk_row(OP_WRITE, 14'h3C00, ST_READONLY, 0, 0, 18'h0));
        // pool empty: evict the dirty page 0 and reuse its frame
        directed.push_back(chk_row(OP_READ,  14'h3C05, ST_OK, 1, 1, 18'h3FC05));
        directed.push_back(ref_row(OP_WRITE, 14'h0555));
        // Frame numbers wrap past the top of the frame field.
        directed.push_back(cfg_row(CFG_FRAME_BASE,    16'h00FE));
        directed.push_back(cfg_row(CFG_FRAME_COUNT,   16'h0010));
        directed.push_back(ref_row(OP_READ,  14'h0AAA));
        directed.push_back(chk_row(OP_READ,  14'h0C00, ST_OK, 1, 0, 18'h00000));
        directed.push_back(ref_row(OP_WRITE, 14'h0BFF));
        // A page dropped from the valid set stays resident and is still a victim.
        directed.push_back(cfg_row(CFG_VALID_MASK,    16'hFFFD));
        directed.push_back(chk_row(OP_READ,  14'h0400, ST_INVALID, 0, 0, 18'h0));
        directed.push_back(cfg_row(CFG_FRAME_COUNT,   16'h0003));
        directed.push_back(chk_row(OP_READ,  14'h1400, ST_OK, 1, 1, 18'h3FC00));
        directed.push_back(cfg_row(CFG_WRITABLE_MASK, 16'hFFFF));
        directed.push_back(ref_row(OP_WRITE, 14'h3FFF));
        directed.push_back(ref_row(OP_READ,  14'h0C00));
        directed.push_back(cfg_row(CFG_VALID_MASK,    16'h0000));
        directed.push_back(chk_row(OP_WRITE, 14'h2000, ST_INVALID, 0, 0, 18'h0));

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG)
                cfg_write(directed[i].reg_idx, directed[i].value);
            else
                send_ref(directed[i]);
        end

        // Random phases, each under a fresh register setting.
        burst_left = 0;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       cnt_sel = 5'd16;
                1:       cnt_sel = 5'd1;
                2:       cnt_sel = 5'd0;
                3:       cnt_sel = 5'd31;
                4:       cnt_sel = 5'd2;
                default: cnt_sel = 5'($urandom_range(1, 16));
            endcase
            cfg_write(CFG_VALID_MASK, (ph == 0) ? 16'hFFFF :
                      (ph == 6) ? 16'($urandom & $urandom) : 16'($urandom | $urandom));
            cfg_write(CFG_WRITABLE_MASK, (ph == 1) ? 16'h0000 :
                      (ph == 2) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
            cfg_write(CFG_FRAME_BASE, (ph == 0) ? 16'h0000 :
                      (ph == 1) ? 16'h00FF : 16'($urandom_range(0, 255)));
            cfg_write(CFG_FRAME_COUNT, {11'd0, cnt_sel});

            for (int n = 0; n < 100; n++) begin
                // one long result-side hold-off while references keep coming
                if (ph == 2 && n == 20)
                    stall_out_req = 1;
                // once, pause until everything in flight has come back
                if (ph == 4 && n == 50)
                    drain_results();
                // bursts with random gaps; phase 5 runs back to back
                if (ph != 5 && burst_left == 0) begin
                    gap = $urandom_range(1, 12);
                    @(negedge i_clk) s_axis_tvalid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                    burst_left = $urandom_range(1, 24);
                end
                if (burst_left > 0)
                    burst_left--;
                pg = pick_page();
                op = t_op'($urandom_range(0, 1));
                if (op == OP_WRITE && !writable_q[pg] && $urandom_range(0, 99) < 80)
                    op = OP_READ;
                row = ref_row(op, {pg, 10'($urandom_range(0, 1023))});
                send_ref(row);
            end
        end

        // Let the block go quiet, then watch for stray words a while longer.
        drain_results();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_xlats.size() == 0) begin
            $display("PASS paged_translation_lru_core");
        end else begin
            $display("FAIL paged_translation_lru_core");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side.
    // ------------------------------------------------------------------

    // Ready pattern: switch between steady, busy and sparse stretches, plus one
    // long hold-off on request so that the core backs up into its input.
    initial begin
        int  mode;
        int  mode_left;
        bit  hold_done;
        mode      = 0;
        mode_left = 0;
        hold_done = 0;
        forever begin
            @(negedge i_clk);
            if (stall_out_req && !hold_done) begin
                hold_done = 1;
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    // Compare every taken result word against the oldest expectation.
    initial begin
        t_xlat exp_x;
        t_xlat got_x;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got_x = t_xlat'(m_axis_tdata[XLAT_W-1:0]);
                if (expected_xlats.size() == 0) begin
                    $error("result word with nothing expected: 0x%0h", m_axis_tdata);
                    mismatches++;
                end else begin
                    exp_x = expected_xlats.pop_front();
                    check_field("status",           32'(exp_x.status),  32'(got_x.status));
                    check_field("page_number",      32'(exp_x.page),    32'(got_x.page));
                    check_field("page_offset",      32'(exp_x.offset),  32'(got_x.offset));
                    check_field("page_fault",       32'(exp_x.fault),   32'(got_x.fault));
                    check_field("write_back",       32'(exp_x.wb),      32'(got_x.wb));
                    check_field("physical_address", 32'(exp_x.phys),    32'(got_x.phys));
                    check_field("read_total",       exp_x.read_total,   got_x.read_total);
                    check_field("write_total",      exp_x.write_total,  got_x.write_total);
                    check_field("fault_total",      exp_x.fault_total,  got_x.fault_total);
                    check_field("writeback_total",  exp_x.wb_total,     got_x.wb_total);
                    check_field("pad", 32'd0, 32'(m_axis_tdata[167:XLAT_W]));
                end
            end
        end
    end

endmodule
